// ===== rtl/ppc_pkg.sv =====
`timescale 1ns / 1ps
package ppc_pkg;

  localparam int PPC_MAX_POINTS = 64;

  localparam int COORD_W = 24;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SQ_W    = 2 * COORD_W + 1;
  localparam int DIST_W  = SQ_W + 2;
  localparam int SEP_W   = 24;
  localparam int LIMIT_W = 2 * SEP_W;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic REG_MIN_SEP = 1'b0;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic wr;
    logic cmp_en;
  } cell_ctl_t;

endpackage

// ===== rtl/ppc_if.sv =====
`timescale 1ns / 1ps
interface ppc_in_if;
  import ppc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] pos_z;
  logic                      last_point;

  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  output last_point, input ready);
  modport sink (input valid, input pos_x, input pos_y, input pos_z,
                input last_point, output ready);
endinterface

interface ppc_out_if;
  logic valid;
  logic ready;
  logic collision_found;
  logic set_overflow;

  modport source (output valid, output collision_found, output set_overflow,
                  input ready);
  modport sink (input valid, input collision_found, input set_overflow,
                output ready);
endinterface

// ===== rtl/ppc_cfg.sv =====
`timescale 1ns / 1ps
module ppc_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ppc_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [ppc_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [ppc_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  output logic [ppc_pkg::LIMIT_W-1:0]       limit
);
  import ppc_pkg::*;

  logic [SEP_W-1:0] min_sep;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_sep <= '0;
      limit   <= '0;
    end else begin
      if (wr_en && (paddr[2] == REG_MIN_SEP)) begin
        min_sep <= pwdata[SEP_W-1:0];
      end
      // Squared separation, so the cells never need a square root.
      limit <= min_sep * min_sep;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MIN_SEP: prdata = {{(APB_DATA_W-SEP_W){1'b0}}, min_sep};
      default:     prdata = '0;
    endcase
  end

endmodule

// ===== rtl/ppc_cell.sv =====
`timescale 1ns / 1ps
module ppc_cell (
  input  logic                         clk,
  input  ppc_pkg::cell_ctl_t           ctl,
  input  ppc_pkg::point_t              wr_point,
  input  logic [ppc_pkg::LIMIT_W-1:0]  limit,
  input  ppc_pkg::point_t              cand_in,
  input  logic                         hit_in,
  output ppc_pkg::point_t              cand_out,
  output logic                         hit_out
);
  import ppc_pkg::*;

  point_t                    stored;
  logic signed [DIFF_W-1:0]  dx, dy, dz;
  logic signed [2*DIFF_W-1:0] px, py, pz;
  logic [SQ_W-1:0]           sq_x, sq_y, sq_z;
  logic [DIST_W-1:0]         dist2;
  logic                      close;

  always_comb begin
    dx = {cand_in.x[COORD_W-1], cand_in.x} - {stored.x[COORD_W-1], stored.x};
    dy = {cand_in.y[COORD_W-1], cand_in.y} - {stored.y[COORD_W-1], stored.y};
    dz = {cand_in.z[COORD_W-1], cand_in.z} - {stored.z[COORD_W-1], stored.z};
    px = dx * dx;
    py = dy * dy;
    pz = dz * dz;
    dist2 = DIST_W'(sq_x) + DIST_W'(sq_y) + DIST_W'(sq_z);
    close = ctl.cmp_en & (dist2 < DIST_W'(limit));
  end

  // The squares are registered behind the candidate, and so is the hit chain,
  // which keeps hit_in and the squares of the same candidate aligned.
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      stored <= wr_point;
    end
    cand_out <= cand_in;
    sq_x     <= px[SQ_W-1:0];
    sq_y     <= py[SQ_W-1:0];
    sq_z     <= pz[SQ_W-1:0];
    hit_out  <= hit_in | close;
  end

endmodule

// ===== rtl/pairwise_proximity_check_unit.sv =====
`timescale 1ns / 1ps
// Pairwise proximity check over a set of 3-D points.
// Points arrive as beats on in_pt (pos_x, pos_y, pos_z, last_point); a set
// ends with the beat that has last_point high. Each point is compared with
// every point stored earlier in the set and is also stored in the next free
// cell, or flagged as overflow once MAX_POINTS cells are full.
// On the last point one beat leaves on out_pt with collision_found and
// set_overflow; the set state is then cleared. Other points give no beat.
// min_separation is to be written over the APB port only while the block is
// idle; the block itself does not enforce this. Each point occupies the block
// while its candidate walks the row of cells one cell per cycle and then the
// squaring and compare stage of the last cell; in_pt.ready is low meanwhile.
// out_pt.valid rises once the last point has cleared the last cell.
// The result sits in an output register; a stalled out_pt only holds the
// block back when the next set ends before the previous result is taken.
// Reset clears the counters, flags and min_separation; the point store needs
// no clearing pass, as only cells filled within the current set are compared.
module pairwise_proximity_check_unit #(
  parameter int MAX_POINTS = ppc_pkg::PPC_MAX_POINTS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ppc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [ppc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [ppc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  ppc_in_if.sink                          in_pt,
  ppc_out_if.source                       out_pt
);
  import ppc_pkg::*;

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int TMR_W = $clog2(MAX_POINTS + 2);
  localparam logic [TMR_W-1:0] TMR_INIT = TMR_W'(MAX_POINTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_POINTS);

  logic [LIMIT_W-1:0] limit;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   n_cmp;
  logic [TMR_W-1:0]   timer;
  logic               busy;
  logic               last_q;
  logic               collision_seen;
  logic               overflow_seen;
  logic               out_valid;
  logic               out_coll;
  logic               out_ovf;
  point_t             entry;
  point_t             in_point;
  logic               accept;
  logic               finish;
  logic               coll_next;

  point_t             cand [0:MAX_POINTS];
  logic               hit  [0:MAX_POINTS];
  cell_ctl_t          ctl  [0:MAX_POINTS-1];

  ppc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limit   (limit)
  );

  assign in_point.x = in_pt.pos_x;
  assign in_point.y = in_pt.pos_y;
  assign in_point.z = in_pt.pos_z;

  assign in_pt.ready = !busy;
  assign accept      = in_pt.valid && in_pt.ready;

  assign out_pt.valid           = out_valid;
  assign out_pt.collision_found = out_coll;
  assign out_pt.set_overflow    = out_ovf;

  assign cand[0] = entry;
  assign hit[0]  = 1'b0;

  genvar i;
  generate
    for (i = 0; i < MAX_POINTS; i++) begin : g_cell
      assign ctl[i].wr     = accept && (count == CNT_W'(i));
      assign ctl[i].cmp_en = CNT_W'(i) < n_cmp;

      ppc_cell u_cell (
        .clk      (clk),
        .ctl      (ctl[i]),
        .wr_point (in_point),
        .limit    (limit),
        .cand_in  (cand[i]),
        .hit_in   (hit[i]),
        .cand_out (cand[i+1]),
        .hit_out  (hit[i+1])
      );
    end
  endgenerate

  // A finished last point waits here until the previous result has left.
  assign finish    = busy && (timer == '0) && (!last_q || !out_valid || out_pt.ready);
  assign coll_next = collision_seen | hit[MAX_POINTS];

  always_ff @(posedge clk) begin
    if (accept) begin
      entry <= in_point;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count          <= '0;
      n_cmp          <= '0;
      timer          <= '0;
      busy           <= 1'b0;
      last_q         <= 1'b0;
      collision_seen <= 1'b0;
      overflow_seen  <= 1'b0;
      out_valid      <= 1'b0;
      out_coll       <= 1'b0;
      out_ovf        <= 1'b0;
    end else begin
      if (finish && last_q) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_pt.ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        busy   <= 1'b1;
        timer  <= TMR_INIT;
        n_cmp  <= count;
        last_q <= in_pt.last_point;
        if (count < CNT_MAX) begin
          count <= count + CNT_W'(1);
        end else begin
          overflow_seen <= 1'b1;
        end
      end else if (busy && (timer != '0)) begin
        timer <= timer - TMR_W'(1);
      end else if (finish) begin
        busy <= 1'b0;
        if (last_q) begin
          out_coll       <= coll_next;
          out_ovf        <= overflow_seen;
          count          <= '0;
          collision_seen <= 1'b0;
          overflow_seen  <= 1'b0;
        end else begin
          collision_seen <= coll_next;
        end
      end
    end
  end

endmodule
